@@ rtl/stable_priority_queue_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the stable priority queue core
// Concurrent assertion shorthands that share one clock and reset.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_CORE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_CORE_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// Stable priority queue package
// Sizes, codes and shared types of the sorted cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int RANK_W   = 16;
    localparam int FILL_W   = 5;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_ENQ   = 2'd0,
        ST_FULL  = 2'd1,
        ST_DEQ   = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [RANK_W-1:0]       rank;
    } t_entry;

    typedef struct packed {
        logic   enq;
        logic   deq;
        t_entry item;
    } t_cell_ctrl;

    typedef struct packed {
        t_entry entry;
        logic   gt;
        logic   occ;
    } t_link;

endpackage

@@ rtl/spq_cell.sv @@
// ----------------------------------------------------------------------------
// Stable priority queue cell
// One sorted position: holds an entry, compares it with the incoming rank and
// takes a neighbour's entry or the new item when the chain shifts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell (
    input  logic                i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  spq_pkg::t_link      i_left,
    input  spq_pkg::t_entry     i_right_entry,
    input  logic                i_occ,
    output spq_pkg::t_link      o_link
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   w_gt;

    assign w_gt = i_occ && (r_entry.rank > i_ctrl.item.rank);

    assign o_link.entry = r_entry;
    assign o_link.gt    = w_gt;
    assign o_link.occ   = i_occ;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.enq) begin
            if (i_left.gt) begin
                n_entry = i_left.entry;
            end else if (w_gt || (!i_occ && i_left.occ)) begin
                n_entry = i_ctrl.item;
            end
        end else if (i_ctrl.deq) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

@@ rtl/stable_priority_queue_core.sv @@
// The result of an operation is strobed in the cycle after its transfer.
// Throughput: one operation per cycle; every cell of the chain compares and
// shifts in the same cycle, so busy stays low.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset clears the fill count and the result strobe; entry contents are left.
// ----------------------------------------------------------------------------
// Stable priority queue core
// Sorted chain of cells, lowest rank at the front, equal ranks in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stable_priority_queue_core_macros.svh"

module stable_priority_queue_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_mode,
    input  logic signed [spq_pkg::KEY_W-1:0] i_item_key,
    input  logic [spq_pkg::RANK_W-1:0]   i_item_rank,
    output logic                         o_done,
    output logic [1:0]                   o_status,
    output logic signed [spq_pkg::KEY_W-1:0] o_out_key,
    output logic [spq_pkg::RANK_W-1:0]   o_out_rank,
    output logic [spq_pkg::FILL_W-1:0]   o_fill_count
);
    import spq_pkg::*;

    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    t_cell_ctrl         w_ctrl;
    t_link              w_link [0:CAPACITY];
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_done;
    t_status            r_status;
    t_status            n_status;
    t_entry             r_out;
    t_entry             n_out;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_empty  = (r_count == '0);

    assign w_ctrl.enq       = w_accept && (i_mode == MODE_ENQ) && !w_full;
    assign w_ctrl.deq       = w_accept && (i_mode == MODE_DEQ) && !w_empty;
    assign w_ctrl.item.key  = i_item_key;
    assign w_ctrl.item.rank = i_item_rank;

    assign w_link[0].entry = '0;
    assign w_link[0].gt    = 1'b0;
    assign w_link[0].occ   = 1'b1;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_right;
        logic   w_occ;

        assign w_occ = (r_count > CNT_W'(g));

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_link[g+2].entry;
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_left        (w_link[g]),
            .i_right_entry (w_right),
            .i_occ         (w_occ),
            .o_link        (w_link[g+1])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_out    = '0;
        if (i_mode == MODE_ENQ) begin
            n_status = w_full ? ST_FULL : ST_ENQ;
        end else begin
            n_status = w_empty ? ST_EMPTY : ST_DEQ;
        end
        if (w_ctrl.enq) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.deq) begin
            n_count = r_count - CNT_W'(1);
            n_out   = w_link[1].entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= w_accept;
        end
        if (w_accept) begin
            r_status <= n_status;
            r_out    <= n_out;
        end
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_out_key    = r_out.key;
    assign o_out_rank   = r_out.rank;
    assign o_fill_count = FILL_W'(r_count);

    `SPQ_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(CAPACITY), "Fill count beyond capacity")
    `SPQ_ASSERT_NEXT(a_done_follows, w_accept, o_done, "Transfer without result strobe")
    `SPQ_ASSERT_NEXT(a_no_spurious, !w_accept, !o_done, "Result strobe without transfer")
    `SPQ_ASSERT_NEXT(a_enq_count, w_ctrl.enq, r_count == $past(r_count) + CNT_W'(1), "Enqueue count slip")
    `SPQ_ASSERT_SAME(a_sorted_front, r_count >= CNT_W'(2), w_link[1].entry.rank <= w_link[2].entry.rank, "Front cells out of order")

endmodule

@@ bench/stable_priority_queue_core_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue core checker
// Follows every transfer into the core with its own sorted store and count,
// predicts the result of each operation and compares every strobed result,
// field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------

module stable_priority_queue_core_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic                              i_mode,
    input  logic signed [spq_pkg::KEY_W-1:0]  i_item_key,
    input  logic [spq_pkg::RANK_W-1:0]        i_item_rank,
    input  logic                              i_done,
    input  logic [1:0]                        i_status,
    input  logic signed [spq_pkg::KEY_W-1:0]  i_out_key,
    input  logic [spq_pkg::RANK_W-1:0]        i_out_rank,
    input  logic [spq_pkg::FILL_W-1:0]        i_fill_count,
    output int                                o_errors,
    output int                                o_outstanding
);
    import spq_pkg::*;

    typedef struct {
        t_status                 status;
        logic signed [KEY_W-1:0] key;
        logic [RANK_W-1:0]       rank;
        logic [FILL_W-1:0]       fill;
    } t_outcome;

    t_entry   sorted_store [CAPACITY];
    int       store_count;
    t_outcome awaited_outcomes [$];

    initial begin
        o_errors      = 0;
        o_outstanding = 0;
        store_count   = 0;
    end

    function automatic t_outcome serve_operation(input logic mode,
                                                 input logic signed [KEY_W-1:0] key,
                                                 input logic [RANK_W-1:0] rank);
        t_outcome res;
        int       pos;
        int       i;
        res.key  = '0;
        res.rank = '0;
        if (mode == MODE_ENQ) begin
            if (store_count >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                pos = store_count;
                for (i = 0; i < store_count; i++) begin
                    if (pos == store_count && sorted_store[i].rank > rank) begin
                        pos = i;
                    end
                end
                for (i = store_count; i > pos; i--) begin
                    sorted_store[i] = sorted_store[i-1];
                end
                sorted_store[pos].key  = key;
                sorted_store[pos].rank = rank;
                store_count++;
                res.status = ST_ENQ;
            end
        end else begin
            if (store_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.key  = sorted_store[0].key;
                res.rank = sorted_store[0].rank;
                for (i = 1; i < store_count; i++) begin
                    sorted_store[i-1] = sorted_store[i];
                end
                store_count--;
                res.status = ST_DEQ;
            end
        end
        res.fill = store_count[FILL_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome exp;
        if (!i_rst_n) begin
            store_count = 0;
            awaited_outcomes.delete();
        end else begin
            if (i_done !== 1'b0) begin
                if (awaited_outcomes.size() == 0) begin
                    $display("%0t: result with nothing awaited: status %0d key %0d rank %0d fill %0d",
                             $time, i_status, i_out_key, i_out_rank, i_fill_count);
                    o_errors++;
                end else begin
                    exp = awaited_outcomes.pop_front();
                    if (i_status !== exp.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp.status, i_status);
                        o_errors++;
                    end
                    if (i_out_key !== exp.key) begin
                        $display("%0t: out_key expected %0d actual %0d",
                                 $time, exp.key, i_out_key);
                        o_errors++;
                    end
                    if (i_out_rank !== exp.rank) begin
                        $display("%0t: out_rank expected %0d actual %0d",
                                 $time, exp.rank, i_out_rank);
                        o_errors++;
                    end
                    if (i_fill_count !== exp.fill) begin
                        $display("%0t: fill_count expected %0d actual %0d",
                                 $time, exp.fill, i_fill_count);
                        o_errors++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                awaited_outcomes.push_back(serve_operation(i_mode, i_item_key, i_item_rank));
            end
        end
        o_outstanding = awaited_outcomes.size();
    end

endmodule

@@ bench/stable_priority_queue_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue core testbench
// Drives directed and random enqueue and dequeue transfers with random gaps,
// reaching full and empty many times with many equal ranks, and gives the
// verdict from the failure count of the checker beside the core.
// ----------------------------------------------------------------------------

module stable_priority_queue_core_tb;
    import spq_pkg::*;

    localparam int RANDOM_OPS  = 1600;
    localparam int CYCLE_LIMIT = 200000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic                    op_mode;
    logic signed [KEY_W-1:0] op_key;
    logic [RANK_W-1:0]       op_rank;
    logic                    done;
    logic [1:0]              res_status;
    logic signed [KEY_W-1:0] res_key;
    logic [RANK_W-1:0]       res_rank;
    logic [FILL_W-1:0]       res_fill;
    int                      errors;
    int                      outstanding;
    int                      cycle_count;
    bit                      quiet;

    stable_priority_queue_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (op_mode),
        .i_item_key   (op_key),
        .i_item_rank  (op_rank),
        .o_done       (done),
        .o_status     (res_status),
        .o_out_key    (res_key),
        .o_out_rank   (res_rank),
        .o_fill_count (res_fill)
    );

    stable_priority_queue_core_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_mode        (op_mode),
        .i_item_key    (op_key),
        .i_item_rank   (op_rank),
        .i_done        (done),
        .i_status      (res_status),
        .i_out_key     (res_key),
        .i_out_rank    (res_rank),
        .i_fill_count  (res_fill),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("stable_priority_queue_core_tb: FAIL");
            $finish;
        end
    end

    task automatic idle_cycle();
        @(negedge i_clk);
        start   <= 1'b0;
        op_mode <= 1'($urandom);
        op_key  <= KEY_W'($urandom);
        op_rank <= RANK_W'($urandom);
    endtask

    task automatic issue_op(input logic mode, input logic signed [KEY_W-1:0] key,
                            input logic [RANK_W-1:0] rank);
        while (!quiet && $urandom_range(0, 99) < 17) idle_cycle();
        @(negedge i_clk);
        start   <= 1'b1;
        op_mode <= mode;
        op_key  <= key;
        op_rank <= rank;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain_results();
        idle_cycle();
        while (outstanding != 0) @(negedge i_clk);
    endtask

    function automatic logic [RANK_W-1:0] pick_rank();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return RANK_W'($urandom_range(0, 3));
            5:             return '0;
            6:             return '1;
            default:       return RANK_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 19))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return KEY_W'($urandom);
        endcase
    endfunction

    initial begin
        int enq_pct;
        int n;
        i_rst_n = 1'b0;
        start   = 1'b0;
        op_mode = MODE_ENQ;
        op_key  = '0;
        op_rank = '0;
        quiet   = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        issue_op(MODE_DEQ, 32'sh1234_5678, 16'h1234);
        issue_op(MODE_ENQ, 32'sh7FFF_FFFF, 16'hFFFF);
        issue_op(MODE_ENQ, 32'sh8000_0000, 16'h0000);
        issue_op(MODE_ENQ, -32'sd1, 16'h0000);
        issue_op(MODE_ENQ, 32'sd0, 16'h8000);
        issue_op(MODE_ENQ, 32'sd1, 16'h0000);
        issue_op(MODE_ENQ, 32'sh5555_5555, 16'hFFFF);
        for (n = 0; n < 10; n++) begin
            issue_op(MODE_ENQ, KEY_W'($urandom), RANK_W'(n % 3));
        end
        issue_op(MODE_ENQ, 32'shAAAA_AAAA, 16'h0000);
        issue_op(MODE_DEQ, '0, '0);
        issue_op(MODE_DEQ, '1, '1);
        issue_op(MODE_DEQ, '0, '0);
        issue_op(MODE_ENQ, 32'sh0F0F_0F0F, 16'h0001);

        enq_pct = 50;
        for (n = 0; n < RANDOM_OPS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 4))
                    0:       enq_pct = 85;
                    1:       enq_pct = 15;
                    2:       enq_pct = 70;
                    3:       enq_pct = 30;
                    default: enq_pct = 50;
                endcase
            end
            quiet = (n >= 300 && n < 600);
            if (n == 900 || n == 1300) drain_results();
            if ($urandom_range(0, 99) < enq_pct) begin
                issue_op(MODE_ENQ, pick_key(), pick_rank());
            end else begin
                issue_op(MODE_DEQ, KEY_W'($urandom), RANK_W'($urandom));
            end
        end

        drain_results();
        repeat (4) @(negedge i_clk);
        if (errors == 0) begin
            $display("stable_priority_queue_core_tb: PASS");
        end else begin
            $display("stable_priority_queue_core_tb: FAIL");
        end
        $finish;
    end

endmodule
